[rtl/core/signed_binary_to_packed_bcd_macros.svh]
// assertion macros for the signed binary to packed bcd converter
// used by the checker file only, no other dependencies
`ifndef SIGNED_BINARY_TO_PACKED_BCD_MACROS_SVH
`define SIGNED_BINARY_TO_PACKED_BCD_MACROS_SVH

// clocked check, disabled while reset is asserted
`define SBCD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define SBCD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/sbcd_pkg.sv]
// shared types, constants and register codes of the packed bcd converter
// no dependencies
`timescale 1ns / 1ps

package sbcd_pkg;

    localparam int MAX_BYTES_DEF = 8;
    localparam int VALUE_W       = 33;
    localparam int SCALE_W       = 32;
    localparam int MAG_W         = 48;
    localparam int FRAC_W        = 16;
    localparam int NUM_BYTES_W   = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int BITS_PER_STEP = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER = 2'd2;

    localparam logic [SCALE_W-1:0]     SCALE_RST      = 32'h0001_0000;
    localparam logic [NUM_BYTES_W-1:0] NUM_BYTES_RST  = 4'd4;
    localparam logic                   BYTE_ORDER_RST = 1'b0;

    localparam logic [7:0] SIGN_MASK = 8'h80;

    typedef struct packed {
        logic [MAG_W-1:0]       mag;
        logic                   neg;
        logic [NUM_BYTES_W-1:0] len;
        logic                   order;
    } t_job;

endpackage

[rtl/core/sbcd_intf.sv]
// channel interfaces of the packed bcd converter: input value and output byte
// depends on sbcd_pkg
`timescale 1ns / 1ps

interface sbcd_in_if;
    import sbcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface sbcd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] bcd_byte;
    logic       last;

    modport source (output valid, output bcd_byte, output last, input ready);
    modport sink (input valid, input bcd_byte, input last, output ready);
endinterface

[rtl/core/sbcd_front.sv]
// front end: takes one value, clamps the byte count, scales by the q16.16 factor
// depends on sbcd_pkg
`timescale 1ns / 1ps

module sbcd_front #(
    parameter int MAX_BYTES = sbcd_pkg::MAX_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sbcd_pkg::VALUE_W-1:0]     i_value,
    input  logic [sbcd_pkg::SCALE_W-1:0]     i_scale,
    input  logic [sbcd_pkg::NUM_BYTES_W-1:0] i_num_bytes,
    input  logic                             i_byte_order,
    output logic                             o_push,
    input  logic                             i_push_ready,
    output sbcd_pkg::t_job                   o_job
);
    import sbcd_pkg::*;

    logic                   r_valid;
    logic [VALUE_W-1:0]     r_mag;
    logic                   r_neg;
    logic [SCALE_W-1:0]     r_scale;
    logic [NUM_BYTES_W-1:0] r_len;
    logic                   r_order;

    logic                   accept;
    logic [VALUE_W-1:0]     n_mag;
    logic [NUM_BYTES_W-1:0] n_len;
    logic [63:0]            prod;
    logic [MAG_W-1:0]       mag_scaled;

    assign o_push  = r_valid && i_push_ready;
    assign o_ready = !r_valid || i_push_ready;
    assign accept  = i_valid && o_ready;

    assign n_mag = i_value[VALUE_W-1] ? (~i_value + VALUE_W'(1)) : i_value;

    always_comb begin
        priority if (i_num_bytes == '0) begin
            n_len = NUM_BYTES_W'(1);
        end else if (i_num_bytes > NUM_BYTES_W'(MAX_BYTES)) begin
            n_len = NUM_BYTES_W'(MAX_BYTES);
        end else begin
            n_len = i_num_bytes;
        end
    end

    // magnitude is at most 2^32, the top bit alone means exactly 2^32
    assign prod = r_mag[VALUE_W-1] ? {r_scale, 32'b0} : (r_mag[31:0] * r_scale);
    assign mag_scaled = prod[MAG_W+FRAC_W-1:FRAC_W];

    assign o_job.mag   = mag_scaled;
    assign o_job.neg   = r_neg && (mag_scaled != '0);
    assign o_job.len   = r_len;
    assign o_job.order = r_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag   <= n_mag;
            r_neg   <= i_value[VALUE_W-1];
            r_scale <= i_scale;
            r_len   <= n_len;
            r_order <= i_byte_order;
        end
    end

endmodule

[rtl/core/sbcd_queue.sv]
// short job queue between the front end and the digit converter
// depends on sbcd_pkg
`timescale 1ns / 1ps

module sbcd_queue #(
    parameter int DEPTH = sbcd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_push_ready,
    input  sbcd_pkg::t_job i_job,
    output logic           o_pop_valid,
    input  logic           i_pop,
    output sbcd_pkg::t_job o_job
);
    import sbcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[rtl/core/sbcd_back.sv]
// back end: shift-add-3 conversion, four bits a cycle, then byte output register
// depends on sbcd_pkg
`timescale 1ns / 1ps

module sbcd_back #(
    parameter int MAX_BYTES = sbcd_pkg::MAX_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_pop,
    input  sbcd_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_bcd_byte,
    output logic           o_last
);
    import sbcd_pkg::*;

    localparam int DIGITS     = 2 * MAX_BYTES;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int IDX_W      = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CONV_STEPS = MAG_W / BITS_PER_STEP;
    localparam int STEP_W     = $clog2(CONV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state                 r_state,   n_state;
    logic [MAG_W-1:0]       r_bin,     n_bin;
    logic [BCD_W-1:0]       r_bcd,     n_bcd;
    logic                   r_neg,     n_neg;
    logic [NUM_BYTES_W-1:0] r_len,     n_len;
    logic                   r_order,   n_order;
    logic [STEP_W-1:0]      r_step,    n_step;
    logic [NUM_BYTES_W-1:0] r_k,       n_k;
    logic                   r_valid,   n_valid;
    logic [7:0]             r_byte,    n_byte;
    logic                   r_last,    n_last;

    function automatic logic [BCD_W-1:0] add3(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] v;
        v = b;
        for (int d = 0; d < DIGITS; d++) begin
            if (v[4*d +: 4] >= 4'd5) begin
                v[4*d +: 4] = v[4*d +: 4] + 4'd3;
            end
        end
        return v;
    endfunction

    assign o_job_pop  = (r_state == S_IDLE) && i_job_valid;
    assign o_valid    = r_valid;
    assign o_bcd_byte = r_byte;
    assign o_last     = r_last;

    always_comb begin
        logic [BCD_W-1:0]       v_bcd;
        logic [MAG_W-1:0]       v_bin;
        logic [NUM_BYTES_W-1:0] src;
        logic [7:0]             pick;

        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        n_len   = r_len;
        n_order = r_order;
        n_step  = r_step;
        n_k     = r_k;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;

        v_bcd = r_bcd;
        v_bin = r_bin;
        src   = r_order ? r_k : (r_len - NUM_BYTES_W'(1) - r_k);
        pick  = r_bcd[8*src[IDX_W-1:0] +: 8];
        if (r_neg && (src == r_len - NUM_BYTES_W'(1))) begin
            pick = pick | SIGN_MASK;
        end

        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_bin   = i_job.mag;
                    n_bcd   = '0;
                    n_neg   = i_job.neg;
                    n_len   = i_job.len;
                    n_order = i_job.order;
                    n_step  = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                for (int s = 0; s < BITS_PER_STEP; s++) begin
                    v_bcd = add3(v_bcd);
                    v_bcd = {v_bcd[BCD_W-2:0], v_bin[MAG_W-1]};
                    v_bin = {v_bin[MAG_W-2:0], 1'b0};
                end
                n_bcd  = v_bcd;
                n_bin  = v_bin;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(CONV_STEPS - 1)) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_valid || i_ready) begin
                    n_valid = 1'b1;
                    n_byte  = pick;
                    n_last  = (r_k == r_len - NUM_BYTES_W'(1));
                    n_k     = r_k + NUM_BYTES_W'(1);
                    if (r_k == r_len - NUM_BYTES_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_step  <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_step  <= n_step;
            r_k     <= n_k;
        end
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_neg   <= n_neg;
        r_len   <= n_len;
        r_order <= n_order;
        r_byte  <= n_byte;
        r_last  <= n_last;
    end

endmodule

[rtl/core/signed_binary_to_packed_bcd.sv]
// signed binary to packed bcd converter with q16.16 scaling
// each item passes the 12-step shift-add-3 converter before its bytes go out
// output bytes go one per cycle while the output is ready; a 2-entry job queue lets the front take items meanwhile
// synchronous active-low reset clears control state and loads register defaults
`timescale 1ns / 1ps

module signed_binary_to_packed_bcd #(
    parameter int MAX_BYTES = sbcd_pkg::MAX_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sbcd_in_if.sink                         i_value_ch,
    sbcd_out_if.source                      o_bcd_ch,
    input  logic                            i_cfg_we,
    input  logic [sbcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sbcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sbcd_pkg::*;

    logic [SCALE_W-1:0]     r_scale;
    logic [NUM_BYTES_W-1:0] r_num_bytes;
    logic                   r_byte_order;

    logic front_push;
    logic queue_ready;
    t_job front_job;
    logic queue_valid;
    logic back_pop;
    t_job queue_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= SCALE_RST;
            r_num_bytes  <= NUM_BYTES_RST;
            r_byte_order <= BYTE_ORDER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE:      r_scale      <= i_cfg_data[SCALE_W-1:0];
                CFG_NUM_BYTES:  r_num_bytes  <= i_cfg_data[NUM_BYTES_W-1:0];
                CFG_BYTE_ORDER: r_byte_order <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sbcd_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_value_ch.valid),
        .o_ready      (i_value_ch.ready),
        .i_value      (i_value_ch.value),
        .i_scale      (r_scale),
        .i_num_bytes  (r_num_bytes),
        .i_byte_order (r_byte_order),
        .o_push       (front_push),
        .i_push_ready (queue_ready),
        .o_job        (front_job)
    );

    sbcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .o_push_ready (queue_ready),
        .i_job        (front_job),
        .o_pop_valid  (queue_valid),
        .i_pop        (back_pop),
        .o_job        (queue_job)
    );

    sbcd_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .o_job_pop   (back_pop),
        .i_job       (queue_job),
        .o_valid     (o_bcd_ch.valid),
        .i_ready     (o_bcd_ch.ready),
        .o_bcd_byte  (o_bcd_ch.bcd_byte),
        .o_last      (o_bcd_ch.last)
    );

endmodule

[rtl/core/sbcd_checker.sv]
// port-level checks of the packed bcd converter and their bind to the top level
// depends on sbcd_pkg and signed_binary_to_packed_bcd_macros.svh
`timescale 1ns / 1ps
`include "signed_binary_to_packed_bcd_macros.svh"

module sbcd_checker #(
    parameter int MAX_BYTES = sbcd_pkg::MAX_BYTES_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);
    import sbcd_pkg::*;

    localparam int RUN_W = $clog2(MAX_BYTES + 1);

    logic [RUN_W-1:0] r_run;
    logic             out_take;

    assign out_take = i_out_valid && i_out_ready;

    // bytes taken so far in the current run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (out_take) begin
            r_run <= i_out_last ? '0 : r_run + RUN_W'(1);
        end
    end

    `SBCD_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "output item dropped while stalled")
    `SBCD_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last), "output item changed while stalled")
    `SBCD_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")
    `SBCD_ASSERT(a_run_len, i_clk, i_rst_n, out_take && !i_out_last |-> r_run < RUN_W'(MAX_BYTES - 1), "byte run longer than the maximum")

endmodule

bind signed_binary_to_packed_bcd sbcd_checker #(
    .MAX_BYTES (MAX_BYTES)
) u_sbcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_bcd_ch.valid),
    .i_out_ready (o_bcd_ch.ready),
    .i_out_byte  (o_bcd_ch.bcd_byte),
    .i_out_last  (o_bcd_ch.last)
);
